### rtl/slfilt_pkg.sv
// ----------------------------------------------------------------------------
// slfilt_pkg: shared types and constants of the stray line-end filter
// Holds the configuration bundle, the command passed from front to back,
// register indexes and the pattern byte lookup.
// ----------------------------------------------------------------------------
package slfilt_pkg;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int CNT_W             = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int PIDX_W            = $clog2(MAX_PATTERN_BYTES);
  // Longest run: line end, full prefix, trailing byte.
  localparam int RUN_W             = $clog2(MAX_PATTERN_BYTES + 3);

  localparam logic [7:0] LINE_END_RESET = 8'h0a;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [1:0] REG_PAT_LOW  = 2'd0;
  localparam logic [1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [1:0] REG_PAT_LEN  = 2'd2;
  localparam logic [1:0] REG_LINE_END = 2'd3;

  typedef struct packed {
    logic [63:0]      pat_lo;
    logic [63:0]      pat_hi;
    logic [CNT_W-1:0] plen;     // already clamped to MAX_PATTERN_BYTES
    logic [7:0]       line_end;
  } cfg_t;

  // One run of results: [line end] [pattern prefix] [trailing byte]
  typedef struct packed {
    logic             lead;
    logic [CNT_W-1:0] pcnt;
    logic             tail_v;
    logic [7:0]       tail_b;
    logic             last;
    logic             err;
  } cmd_t;

  function automatic logic [7:0] pat_byte(input cfg_t cfg, input logic [CNT_W-1:0] k);
    logic [127:0] both;
    both = {cfg.pat_hi, cfg.pat_lo};
    if (k >= CNT_W'(MAX_PATTERN_BYTES)) begin
      return 8'h00;
    end
    return both[{k[PIDX_W-1:0], 3'b000} +: 8];
  endfunction

endpackage

### rtl/stray_linefeed_filter.sv
// ----------------------------------------------------------------------------
// stray_linefeed_filter: drops stray line ends from a marked byte stream
// The first result of an item passes the command queue, then the emitter's
//   output register. Throughput: one result per cycle out of the emitter
//   while results are popped; a run of n results leaves one after another.
// The emitter's single output register sets the rate.
// Reset (rst_ni low, async): no held line end, command queue and output
//   register empty, pattern cleared, line-end byte back to 0x0a.
// ----------------------------------------------------------------------------
module stray_linefeed_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  input  logic        stream_end_i,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        stream_last_o,
  output logic        error_seen_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import slfilt_pkg::*;

  // Configuration registers. The user must write them only while the filter is
  // idle; the block itself does not enforce it, and both halves read them live.
  logic [63:0]      pat_lo_q, pat_hi_q;
  logic [CNT_W-1:0] plen_q;
  logic [7:0]       le_q;
  cfg_t             cfg;

  // Front to back.
  logic             accept;
  logic             cmd_wr;
  cmd_t             cmd_wdata;
  logic             cmd_valid;
  cmd_t             cmd_head;
  logic             cmd_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      plen_q   <= '0;
      le_q     <= LINE_END_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PAT_LOW:  pat_lo_q <= cfg_data_i;
        REG_PAT_HIGH: pat_hi_q <= cfg_data_i;
        REG_PAT_LEN:  plen_q   <= cfg_data_i[CNT_W-1:0];
        REG_LINE_END: le_q     <= cfg_data_i[7:0];
        default:      le_q     <= le_q;
      endcase
    end
  end

  // Lengths beyond the pattern storage clamp to its size.
  always_comb begin
    cfg.pat_lo   = pat_lo_q;
    cfg.pat_hi   = pat_hi_q;
    cfg.line_end = le_q;
    cfg.plen     = (plen_q > CNT_W'(MAX_PATTERN_BYTES)) ? CNT_W'(MAX_PATTERN_BYTES)
                                                        : plen_q;
  end

  // An item is taken whenever the command queue has room, even if it
  // produces no command (a held or dropped line end).
  assign accept = push && !full;

  slfilt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .accept_i     (accept),
    .in_byte_i    (in_byte_i),
    .stream_end_i (stream_end_i),
    .cmd_valid_o  (cmd_wr),
    .cmd_o        (cmd_wdata)
  );

  slfilt_cmdq u_cmdq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cmd_wr),
    .wr_data_i  (cmd_wdata),
    .full_o     (full),
    .rd_en_i    (cmd_pop),
    .rd_valid_o (cmd_valid),
    .rd_data_o  (cmd_head)
  );

  // Emitter: line end, then the matched prefix out of the pattern
  // registers, then the trailing byte, each as a separate result item.
  slfilt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd_head),
    .cmd_pop_o     (cmd_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .stream_last_o (stream_last_o),
    .error_seen_o  (error_seen_o)
  );

endmodule

### rtl/slfilt_front.sv
// ----------------------------------------------------------------------------
// slfilt_front: item classifier
// Tracks the held line end and the pattern match, and turns each item into
// at most one run command for the back end.
// ----------------------------------------------------------------------------
module slfilt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  slfilt_pkg::cfg_t   cfg_i,
  input  logic               accept_i,
  input  logic [7:0]         in_byte_i,
  input  logic               stream_end_i,
  output logic               cmd_valid_o,
  output slfilt_pkg::cmd_t   cmd_o
);
  import slfilt_pkg::*;

  logic             hold_q, hold_d;
  logic [CNT_W-1:0] mcnt_q, mcnt_d;
  logic             err_q, err_d;

  logic             is_le;
  logic             fresh;
  logic [CNT_W-1:0] m1;
  cmd_t             cmd;

  assign is_le = (in_byte_i == cfg_i.line_end);
  assign m1    = mcnt_q + CNT_W'(1);

  always_comb begin
    hold_d     = hold_q;
    mcnt_d     = mcnt_q;
    err_d      = err_q;
    fresh      = 1'b1;
    cmd        = '0;
    cmd.tail_b = in_byte_i;
    cmd.last   = stream_end_i;

    if (hold_q) begin
      priority if (is_le && (mcnt_q == '0)) begin
        hold_d = 1'b0;                    // doubled line end, drop quietly
      end else if (mcnt_q >= cfg_i.plen) begin
        cmd.lead = 1'b1;
        cmd.pcnt = mcnt_q;
        hold_d   = 1'b0;
        mcnt_d   = '0;
      end else if (!is_le && (in_byte_i == pat_byte(cfg_i, mcnt_q))) begin
        fresh = 1'b0;
        priority if (m1 >= cfg_i.plen) begin
          cmd.lead = 1'b1;
          cmd.pcnt = m1;
          hold_d   = 1'b0;
          mcnt_d   = '0;
        end else if (stream_end_i) begin
          err_d    = 1'b1;                // partial match at stream end
          cmd.pcnt = m1;
          hold_d   = 1'b0;
          mcnt_d   = '0;
        end else begin
          mcnt_d = m1;
        end
      end else begin
        err_d    = 1'b1;                  // mismatch: line end dropped
        cmd.pcnt = mcnt_q;
        hold_d   = 1'b0;
        mcnt_d   = '0;
      end
    end

    if (fresh) begin
      if (is_le && !stream_end_i) begin
        hold_d = 1'b1;
        mcnt_d = '0;
      end else begin
        cmd.tail_v = 1'b1;
      end
    end

    cmd.err = err_d;
  end

  assign cmd_o       = cmd;
  assign cmd_valid_o = accept_i && (cmd.lead || (cmd.pcnt != '0) || cmd.tail_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      mcnt_q <= '0;
      err_q  <= 1'b0;
    end else if (accept_i) begin
      if (stream_end_i) begin
        hold_q <= 1'b0;
        mcnt_q <= '0;
        err_q  <= 1'b0;
      end else begin
        hold_q <= hold_d;
        mcnt_q <= mcnt_d;
        err_q  <= err_d;
      end
    end
  end

endmodule

### rtl/slfilt_cmdq.sv
// ----------------------------------------------------------------------------
// slfilt_cmdq: command queue
// Small register queue between classifier and emitter.
// ----------------------------------------------------------------------------
module slfilt_cmdq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  slfilt_pkg::cmd_t wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic             rd_valid_o,
  output slfilt_pkg::cmd_t rd_data_o
);
  import slfilt_pkg::*;

  cmd_t               entry_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wptr_q, rptr_q;
  logic [CMDQ_CW-1:0] cnt_q;

  assign full_o     = (cnt_q == CMDQ_CW'(CMDQ_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = entry_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_en_i) begin
        wptr_q <= wptr_q + CMDQ_AW'(1);
      end
      if (rd_en_i) begin
        rptr_q <= rptr_q + CMDQ_AW'(1);
      end
      unique case ({wr_en_i, rd_en_i})
        2'b10:   cnt_q <= cnt_q + CMDQ_CW'(1);
        2'b01:   cnt_q <= cnt_q - CMDQ_CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### rtl/slfilt_back.sv
// ----------------------------------------------------------------------------
// slfilt_back: run emitter
// Expands the head command into result bytes, one per cycle into an output
// register, stalling while that register is full and not popped.
// ----------------------------------------------------------------------------
module slfilt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  slfilt_pkg::cfg_t cfg_i,
  input  logic             cmd_valid_i,
  input  slfilt_pkg::cmd_t cmd_i,
  output logic             cmd_pop_o,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [7:0]       out_byte_o,
  output logic             run_last_o,
  output logic             stream_last_o,
  output logic             error_seen_o
);
  import slfilt_pkg::*;

  logic [RUN_W-1:0] idx_q;
  logic [RUN_W-1:0] run_len;
  logic [RUN_W-1:0] k;
  logic             at_end;
  logic             step;
  logic [7:0]       sel_byte;

  logic             ov_q;
  logic [7:0]       obyte_q;
  logic             orun_q, olast_q, oerr_q;

  assign run_len = RUN_W'(cmd_i.lead) + RUN_W'(cmd_i.pcnt) + RUN_W'(cmd_i.tail_v);
  assign at_end  = (idx_q == run_len - RUN_W'(1));
  assign k       = idx_q - RUN_W'(cmd_i.lead);
  assign step    = cmd_valid_i && (!ov_q || pop_i);

  always_comb begin
    priority if (cmd_i.lead && (idx_q == '0)) begin
      sel_byte = cfg_i.line_end;
    end else if (k < RUN_W'(cmd_i.pcnt)) begin
      sel_byte = pat_byte(cfg_i, k[CNT_W-1:0]);
    end else begin
      sel_byte = cmd_i.tail_b;
    end
  end

  assign cmd_pop_o = step && at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (step) begin
        idx_q <= at_end ? '0 : idx_q + RUN_W'(1);
        ov_q  <= 1'b1;
      end else if (pop_i) begin
        ov_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      obyte_q <= sel_byte;
      orun_q  <= at_end;
      olast_q <= at_end && cmd_i.last;
      oerr_q  <= cmd_i.err;
    end
  end

  assign empty_o       = !ov_q;
  assign out_byte_o    = obyte_q;
  assign run_last_o    = orun_q;
  assign stream_last_o = olast_q;
  assign error_seen_o  = oerr_q;

endmodule
